FILE: rtl/wshc_pkg.sv
// shared types and constants for the window size hint constraint pipeline
// used by window_size_hint_constrain; no dependencies
package wshc_pkg;

   localparam int DIM_W      = 16;
   localparam int ASP_W      = 24;
   localparam int PROD_W     = DIM_W + ASP_W;
   localparam int FRAC_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int HINT_W     = 2;
   localparam int DIV_STEPS  = DIM_W;

   localparam int WIN_FLOOR_W_DEF = 32;
   localparam int WIN_FLOOR_H_DEF = 32;

   localparam logic [DIM_W-1:0]  DIM_MAX   = {DIM_W{1'b1}};
   localparam logic [PROD_W:0]   HALF_FRAC = (PROD_W+1)'(1) << (FRAC_W - 1);

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_SIZE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SIZE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SIZE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INC_SIZE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_ASPECT  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ASPECT  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_HINT_ENABLE = 3'd6;

   typedef struct packed {
      logic [DIM_W-1:0] req_width;
      logic [DIM_W-1:0] req_height;
      logic             floated;
      logic [DIM_W-1:0] last_width;
      logic [DIM_W-1:0] last_height;
   } wshc_req_type;

   typedef struct packed {
      logic [DIM_W-1:0] out_width;
      logic [DIM_W-1:0] out_height;
      logic             changed;
   } wshc_rsp_type;

   function automatic logic [DIM_W-1:0] sat_sub(input logic [DIM_W-1:0] a,
                                                input logic [DIM_W-1:0] b);
      sat_sub = (a > b) ? (a - b) : '0;
   endfunction

   function automatic logic [DIM_W-1:0] sat_add(input logic [DIM_W-1:0] a,
                                                input logic [DIM_W-1:0] b);
      logic [DIM_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      sat_add = s[DIM_W] ? DIM_MAX : s[DIM_W-1:0];
   endfunction

   // round half up from q16 product, saturate to pixel range
   function automatic logic [DIM_W-1:0] round_q16(input logic [PROD_W-1:0] p);
      logic [PROD_W:0] s;
      s = {1'b0, p} + HALF_FRAC;
      round_q16 = (s[PROD_W:FRAC_W+DIM_W] != '0) ? DIM_MAX
                                                  : s[FRAC_W+DIM_W-1:FRAC_W];
   endfunction

endpackage

FILE: rtl/window_size_hint_constrain.sv
// window size constraint by size hints, fully pipelined
// depends on wshc_pkg
//
// throughput one item per cycle while the output is not held
// stages: clamp/base, aspect multiply, aspect select, 16 remainder steps, base add,
// min/max limit; the remainder chain (one quotient bit per stage) sets the depth
// reset clears all valid bits and sets configuration registers to zero, hint_enable to 1
module window_size_hint_constrain
   import wshc_pkg::*;
#(
   parameter int WIN_FLOOR_W = WIN_FLOOR_W_DEF,
   parameter int WIN_FLOOR_H = WIN_FLOOR_H_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  wshc_req_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output wshc_rsp_type          rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [DIM_W-1:0] MIN_W = DIM_W'(WIN_FLOOR_W);
   localparam logic [DIM_W-1:0] MIN_H = DIM_W'(WIN_FLOOR_H);

   // configuration registers
   logic [CSR_DATA_W-1:0] base_ff, min_ff, max_ff, inc_ff;
   logic [ASP_W-1:0]      min_asp_ff, max_asp_ff;
   logic [HINT_W-1:0]     hint_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= '0;
         min_ff     <= '0;
         max_ff     <= '0;
         inc_ff     <= '0;
         min_asp_ff <= '0;
         max_asp_ff <= '0;
         hint_en_ff <= HINT_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BASE_SIZE:   base_ff    <= csr_wdata;
            CSR_MIN_SIZE:    min_ff     <= csr_wdata;
            CSR_MAX_SIZE:    max_ff     <= csr_wdata;
            CSR_INC_SIZE:    inc_ff     <= csr_wdata;
            CSR_MIN_ASPECT:  min_asp_ff <= csr_wdata[ASP_W-1:0];
            CSR_MAX_ASPECT:  max_asp_ff <= csr_wdata[ASP_W-1:0];
            CSR_HINT_ENABLE: hint_en_ff <= csr_wdata[HINT_W-1:0];
            default: ;
         endcase
      end
   end

   logic [DIM_W-1:0] bw, bh, mw, mh, xw, xh, iw, ih;
   logic             base_is_min, aspect_on;
   assign bw = base_ff[DIM_W-1:0];
   assign bh = base_ff[2*DIM_W-1:DIM_W];
   assign mw = min_ff[DIM_W-1:0];
   assign mh = min_ff[2*DIM_W-1:DIM_W];
   assign xw = max_ff[DIM_W-1:0];
   assign xh = max_ff[2*DIM_W-1:DIM_W];
   assign iw = inc_ff[DIM_W-1:0];
   assign ih = inc_ff[2*DIM_W-1:DIM_W];
   assign base_is_min = (bw == mw) && (bh == mh);
   assign aspect_on   = (min_asp_ff != '0) && (max_asp_ff != '0);

   // whole pipeline moves together; stalls only when the output is held
   logic advance;
   logic rsp_valid_ff;
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // stage 1: minimum clamp, early base subtraction
   logic             s1_valid_ff, s1_hint_ff;
   logic [DIM_W-1:0] s1_w_ff, s1_h_ff, s1_lw_ff, s1_lh_ff;
   logic             s1_hint_in;
   logic [DIM_W-1:0] s1_w_in, s1_h_in, cw, ch;

   always_comb begin
      cw = (req_data.req_width  < MIN_W) ? MIN_W : req_data.req_width;
      ch = (req_data.req_height < MIN_H) ? MIN_H : req_data.req_height;
      s1_hint_in = req_data.floated ? hint_en_ff[0] : hint_en_ff[1];
      s1_w_in = cw;
      s1_h_in = ch;
      if (s1_hint_in && !base_is_min) begin
         s1_w_in = sat_sub(cw, bw);
         s1_h_in = sat_sub(ch, bh);
      end
   end

   // stage 2: aspect products
   logic              s2_valid_ff, s2_hint_ff;
   logic [DIM_W-1:0]  s2_w_ff, s2_h_ff, s2_lw_ff, s2_lh_ff;
   logic [PROD_W-1:0] s2_pa_ff, s2_pb_ff;

   // stage 3: aspect select, late base subtraction
   logic             s3_w_fix, s3_h_fix;
   logic [DIM_W-1:0] s3_w_in, s3_h_in, aw, ah;

   always_comb begin
      s3_w_fix = s2_pa_ff < {{(PROD_W-DIM_W-FRAC_W){1'b0}}, s2_w_ff, {FRAC_W{1'b0}}};
      s3_h_fix = s2_pb_ff < {{(PROD_W-DIM_W-FRAC_W){1'b0}}, s2_h_ff, {FRAC_W{1'b0}}};
      aw = s2_w_ff;
      ah = s2_h_ff;
      if (s2_hint_ff && aspect_on) begin
         priority if (s3_w_fix) aw = round_q16(s2_pa_ff);
         else if (s3_h_fix)     ah = round_q16(s2_pb_ff);
         else                   aw = s2_w_ff;
      end
      s3_w_in = aw;
      s3_h_in = ah;
      if (s2_hint_ff && base_is_min) begin
         s3_w_in = sat_sub(aw, bw);
         s3_h_in = sat_sub(ah, bh);
      end
   end

   // remainder chain: entry 0 is stage 3, each step resolves one dividend bit
   logic             dv_valid_ff [0:DIV_STEPS];
   logic             dv_hint_ff  [0:DIV_STEPS];
   logic [DIM_W-1:0] dv_w_ff     [0:DIV_STEPS];
   logic [DIM_W-1:0] dv_h_ff     [0:DIV_STEPS];
   logic [DIM_W-1:0] dv_lw_ff    [0:DIV_STEPS];
   logic [DIM_W-1:0] dv_lh_ff    [0:DIV_STEPS];
   logic [DIM_W-1:0] dv_rw_ff    [0:DIV_STEPS];
   logic [DIM_W-1:0] dv_rh_ff    [0:DIV_STEPS];
   logic [DIM_W-1:0] dv_rw_in    [1:DIV_STEPS];
   logic [DIM_W-1:0] dv_rh_in    [1:DIV_STEPS];

   always_comb begin
      logic [DIM_W:0] tw, th;
      for (int k = 0; k < DIV_STEPS; k++) begin
         tw = {dv_rw_ff[k], dv_w_ff[k][DIM_W-1-k]};
         th = {dv_rh_ff[k], dv_h_ff[k][DIM_W-1-k]};
         if (tw >= {1'b0, iw}) tw = tw - {1'b0, iw};
         if (th >= {1'b0, ih}) th = th - {1'b0, ih};
         dv_rw_in[k+1] = tw[DIM_W-1:0];
         dv_rh_in[k+1] = th[DIM_W-1:0];
      end
   end

   // stage A: drop remainder, add base back
   logic             sa_valid_ff, sa_hint_ff;
   logic [DIM_W-1:0] sa_w_ff, sa_h_ff, sa_lw_ff, sa_lh_ff;
   logic [DIM_W-1:0] sa_w_in, sa_h_in, qw, qh;

   always_comb begin
      qw = dv_w_ff[DIV_STEPS] - ((iw != '0) ? dv_rw_ff[DIV_STEPS] : '0);
      qh = dv_h_ff[DIV_STEPS] - ((ih != '0) ? dv_rh_ff[DIV_STEPS] : '0);
      sa_w_in = dv_w_ff[DIV_STEPS];
      sa_h_in = dv_h_ff[DIV_STEPS];
      if (dv_hint_ff[DIV_STEPS]) begin
         sa_w_in = sat_add(qw, bw);
         sa_h_in = sat_add(qh, bh);
      end
   end

   // stage B: minimum and maximum limits, change flag
   logic             rsp_hint_ff;
   wshc_rsp_type     rsp_data_ff, rsp_data_in;
   logic [DIM_W-1:0] lw_, lh_;

   always_comb begin
      lw_ = sa_w_ff;
      lh_ = sa_h_ff;
      if (sa_hint_ff) begin
         if (lw_ < mw) lw_ = mw;
         if (lh_ < mh) lh_ = mh;
         if (xw != '0 && lw_ > xw) lw_ = xw;
         if (xh != '0 && lh_ > xh) lh_ = xh;
      end
      rsp_data_in.out_width  = lw_;
      rsp_data_in.out_height = lh_;
      rsp_data_in.changed    = (lw_ != sa_lw_ff) || (lh_ != sa_lh_ff);
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         for (int k = 0; k <= DIV_STEPS; k++) dv_valid_ff[k] <= 1'b0;
         sa_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff    <= req_valid;
         s2_valid_ff    <= s1_valid_ff;
         dv_valid_ff[0] <= s2_valid_ff;
         for (int k = 0; k < DIV_STEPS; k++) dv_valid_ff[k+1] <= dv_valid_ff[k];
         sa_valid_ff    <= dv_valid_ff[DIV_STEPS];
         rsp_valid_ff   <= sa_valid_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_hint_ff <= s1_hint_in;
         s1_w_ff    <= s1_w_in;
         s1_h_ff    <= s1_h_in;
         s1_lw_ff   <= req_data.last_width;
         s1_lh_ff   <= req_data.last_height;

         s2_hint_ff <= s1_hint_ff;
         s2_w_ff    <= s1_w_ff;
         s2_h_ff    <= s1_h_ff;
         s2_lw_ff   <= s1_lw_ff;
         s2_lh_ff   <= s1_lh_ff;
         s2_pa_ff   <= PROD_W'(max_asp_ff) * PROD_W'(s1_h_ff);
         s2_pb_ff   <= PROD_W'(min_asp_ff) * PROD_W'(s1_w_ff);

         dv_hint_ff[0] <= s2_hint_ff;
         dv_w_ff[0]    <= s3_w_in;
         dv_h_ff[0]    <= s3_h_in;
         dv_lw_ff[0]   <= s2_lw_ff;
         dv_lh_ff[0]   <= s2_lh_ff;
         dv_rw_ff[0]   <= '0;
         dv_rh_ff[0]   <= '0;
         for (int k = 0; k < DIV_STEPS; k++) begin
            dv_hint_ff[k+1] <= dv_hint_ff[k];
            dv_w_ff[k+1]    <= dv_w_ff[k];
            dv_h_ff[k+1]    <= dv_h_ff[k];
            dv_lw_ff[k+1]   <= dv_lw_ff[k];
            dv_lh_ff[k+1]   <= dv_lh_ff[k];
            dv_rw_ff[k+1]   <= dv_rw_in[k+1];
            dv_rh_ff[k+1]   <= dv_rh_in[k+1];
         end

         sa_hint_ff <= dv_hint_ff[DIV_STEPS];
         sa_w_ff    <= sa_w_in;
         sa_h_ff    <= sa_h_in;
         sa_lw_ff   <= dv_lw_ff[DIV_STEPS];
         sa_lh_ff   <= dv_lh_ff[DIV_STEPS];

         rsp_hint_ff <= sa_hint_ff;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a held result must freeze the input side
   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input accepted while result held");

   // frozen pipeline keeps its first stage
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(s1_valid_ff))
      else $error("stage 1 moved during stall");

   // without hints the result never drops below the minimum window size
   a_min_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hint_ff |-> rsp_data.out_width >= MIN_W
                                 && rsp_data.out_height >= MIN_H)
      else $error("unhinted result below minimum size");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule
